@@ hw/rtl/crp_pkg.sv @@
// shared types, constants and helpers of the crop and pad stream block
`default_nettype none
package crp_pkg;

  // working width of the geometry arithmetic, covers sizes up to 16384 plus borders
  localparam int unsigned DW = 16;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned RLW = 26;
  localparam logic [RLW-1:0] RUN_MAX = 26'd50331648;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW = $clog2(QDEPTH);
  localparam int unsigned QCW = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_EDGE_LEFT    = 3'd2,
    REG_EDGE_RIGHT   = 3'd3,
    REG_EDGE_TOP     = 3'd4,
    REG_EDGE_BOTTOM  = 3'd5,
    REG_FILL_COLOUR  = 3'd6,
    REG_ALPHA_VALUES = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    FILL_BLACK     = 2'd0,
    FILL_KEY_GREEN = 2'd1,
    FILL_KEY_BLUE  = 2'd2
  } fill_colour_e;

  // result kinds of one request, emitted lowest bit first
  localparam int unsigned F_TOP     = 0;
  localparam int unsigned F_LEFT    = 1;
  localparam int unsigned F_PIX     = 2;
  localparam int unsigned F_RIGHT   = 3;
  localparam int unsigned F_BOT     = 4;
  localparam int unsigned F_ENDFILL = 5;
  localparam int unsigned NFLAGS    = 6;

  typedef struct packed {
    logic [NFLAGS-1:0] flags;
    logic              fend;
    logic [7:0]        y;
    logic [7:0]        u;
    logic [7:0]        v;
  } job_t;

  typedef struct packed {
    logic [12:0]   frame_width;
    logic [12:0]   frame_height;
    logic [1:0]    fill_colour;
    logic [15:0]   alpha;
    logic [DW-1:0] cl;
    logic [DW-1:0] ct;
    logic [DW-1:0] bl;
    logic [DW-1:0] br;
    logic [DW-1:0] col_end;
    logic [DW-1:0] col_last;
    logic [DW-1:0] row_end;
    logic          win_ok;
    logic          top_en;
    logic          bot_en;
    logic [PW-1:0] top_len;
    logic [PW-1:0] bot_len;
  } cfg_t;

  function automatic logic [DW-1:0] clamp_size(logic [12:0] v, logic [DW-1:0] hi);
    logic [DW-1:0] s;
    s = {{(DW-13){1'b0}}, v};
    if (s == '0) begin
      return DW'(1);
    end else if (s > hi) begin
      return hi;
    end
    return s;
  endfunction

  // {y, u, v} of the border colour, reserved code reads as black
  function automatic logic [23:0] fill_yuv(logic [1:0] fc);
    logic [23:0] r;
    case (fill_colour_e'(fc))
      FILL_KEY_GREEN: r = {8'd150, 8'd46, 8'd21};
      FILL_KEY_BLUE:  r = {8'd29, 8'd255, 8'd107};
      default:        r = {8'd16, 8'd128, 8'd128};
    endcase
    return r;
  endfunction

  function automatic logic [RLW-1:0] sat_len(logic [PW-1:0] p);
    if (p > PW'(RUN_MAX)) begin
      return RUN_MAX;
    end
    return p[RLW-1:0];
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/crp_regs.sv @@
// configuration registers and registered window geometry
`default_nettype none
module crp_regs #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output crp_pkg::cfg_t     cfg_o
);

  localparam int unsigned DW = crp_pkg::DW;
  localparam int unsigned PW = crp_pkg::PW;

  logic [12:0] frame_width_q, frame_height_q;
  logic [12:0] edge_left_q, edge_right_q, edge_top_q, edge_bottom_q;
  logic [1:0]  fill_colour_q;
  logic [15:0] alpha_q;

  logic                 wr_en;
  crp_pkg::reg_idx_e    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = crp_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= 13'd320;
      frame_height_q <= 13'd240;
      edge_left_q    <= '0;
      edge_right_q   <= '0;
      edge_top_q     <= '0;
      edge_bottom_q  <= '0;
      fill_colour_q  <= '0;
      alpha_q        <= 16'hFFFF;
    end else if (wr_en) begin
      case (idx)
        crp_pkg::REG_FRAME_WIDTH:  frame_width_q  <= pwdata[12:0];
        crp_pkg::REG_FRAME_HEIGHT: frame_height_q <= pwdata[12:0];
        crp_pkg::REG_EDGE_LEFT:    edge_left_q    <= pwdata[12:0];
        crp_pkg::REG_EDGE_RIGHT:   edge_right_q   <= pwdata[12:0];
        crp_pkg::REG_EDGE_TOP:     edge_top_q     <= pwdata[12:0];
        crp_pkg::REG_EDGE_BOTTOM:  edge_bottom_q  <= pwdata[12:0];
        crp_pkg::REG_FILL_COLOUR:  fill_colour_q  <= pwdata[1:0];
        crp_pkg::REG_ALPHA_VALUES: alpha_q        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      crp_pkg::REG_FRAME_WIDTH:  prdata = {19'd0, frame_width_q};
      crp_pkg::REG_FRAME_HEIGHT: prdata = {19'd0, frame_height_q};
      crp_pkg::REG_EDGE_LEFT:    prdata = {19'd0, edge_left_q};
      crp_pkg::REG_EDGE_RIGHT:   prdata = {19'd0, edge_right_q};
      crp_pkg::REG_EDGE_TOP:     prdata = {19'd0, edge_top_q};
      crp_pkg::REG_EDGE_BOTTOM:  prdata = {19'd0, edge_bottom_q};
      crp_pkg::REG_FILL_COLOUR:  prdata = {30'd0, fill_colour_q};
      crp_pkg::REG_ALPHA_VALUES: prdata = {16'd0, alpha_q};
      default:                   prdata = '0;
    endcase
  end

  function automatic logic [DW-1:0] pos13(logic [12:0] e);
    return e[12] ? '0 : {{(DW-13){1'b0}}, e};
  endfunction

  // magnitude of a negative edge, -4096 gives 4096
  function automatic logic [DW-1:0] neg13(logic [12:0] e);
    logic [12:0] m;
    m = ~e + 13'd1;
    return e[12] ? {{(DW-13){1'b0}}, m} : '0;
  endfunction

  // first stage: window bounds
  logic [DW-1:0]        w, h, cl, cr, ct, cb, bl, br, bt, bb;
  logic signed [DW+1:0] cw_s, ch_s;
  logic [DW-1:0]        cw, ch, ow;

  always_comb begin
    w  = crp_pkg::clamp_size(frame_width_q, DW'(MAX_WIDTH));
    h  = crp_pkg::clamp_size(frame_height_q, DW'(MAX_HEIGHT));
    cl = pos13(edge_left_q);
    cr = pos13(edge_right_q);
    ct = pos13(edge_top_q);
    cb = pos13(edge_bottom_q);
    bl = neg13(edge_left_q);
    br = neg13(edge_right_q);
    bt = neg13(edge_top_q);
    bb = neg13(edge_bottom_q);
    cw_s = $signed({2'b00, w}) - $signed({2'b00, cl}) - $signed({2'b00, cr});
    ch_s = $signed({2'b00, h}) - $signed({2'b00, ct}) - $signed({2'b00, cb});
    cw = cw_s[DW+1] ? '0 : cw_s[DW-1:0];
    ch = ch_s[DW+1] ? '0 : ch_s[DW-1:0];
    ow = bl + cw + br;
  end

  logic [DW-1:0] cl_q, ct_q, bl_q, br_q, bt_q, bb_q, ow_q;
  logic [DW-1:0] col_end_q, row_end_q;
  logic          win_ok_q, top_en_q, bot_en_q;
  logic [PW-1:0] top_len_q, bot_len_q;

  always_ff @(posedge clk_i) begin
    cl_q      <= cl;
    ct_q      <= ct;
    bl_q      <= bl;
    br_q      <= br;
    bt_q      <= bt;
    bb_q      <= bb;
    ow_q      <= ow;
    col_end_q <= cl + cw;
    row_end_q <= ct + ch;
    win_ok_q  <= (cw != '0) && (ch != '0);
    top_en_q  <= (bt != '0) && (ow != '0);
    bot_en_q  <= (bb != '0) && (ow != '0);
    // second stage: top and bottom run sizes
    top_len_q <= PW'(bt_q) * PW'(ow_q);
    bot_len_q <= PW'(bb_q) * PW'(ow_q);
  end

  always_comb begin
    cfg_o.frame_width  = frame_width_q;
    cfg_o.frame_height = frame_height_q;
    cfg_o.fill_colour  = fill_colour_q;
    cfg_o.alpha        = alpha_q;
    cfg_o.cl           = cl_q;
    cfg_o.ct           = ct_q;
    cfg_o.bl           = bl_q;
    cfg_o.br           = br_q;
    cfg_o.col_end      = col_end_q;
    cfg_o.col_last     = col_end_q - DW'(1);
    cfg_o.row_end      = row_end_q;
    cfg_o.win_ok       = win_ok_q;
    cfg_o.top_en       = top_en_q;
    cfg_o.bot_en       = bot_en_q;
    cfg_o.top_len      = top_len_q;
    cfg_o.bot_len      = bot_len_q;
  end

endmodule
`default_nettype wire

@@ hw/rtl/crp_front.sv @@
// front: pixel intake, raster counters and result classification
`default_nettype none
module crp_front #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [7:0]    luma_i,
  input  wire logic [7:0]    chroma_u_i,
  input  wire logic [7:0]    chroma_v_i,
  input  wire crp_pkg::cfg_t cfg_i,
  input  wire logic          q_full_i,
  output logic               q_push_o,
  output crp_pkg::job_t      q_job_o
);

  localparam int unsigned DW  = crp_pkg::DW;
  localparam int unsigned CXW = $clog2(MAX_WIDTH);
  localparam int unsigned CYW = $clog2(MAX_HEIGHT);

  logic [CXW-1:0] col_q, col_d;
  logic [CYW-1:0] row_q, row_d;
  logic [DW-1:0]  w_now, h_now;
  logic           last_col, last_row, accept;

  // held request
  logic           s1_v_q, s1_v_d;
  logic [CXW-1:0] s1_col_q;
  logic [CYW-1:0] s1_row_q;
  logic           s1_last_q;
  logic [7:0]     s1_y_q, s1_u_q, s1_v_data_q;

  assign w_now    = crp_pkg::clamp_size(cfg_i.frame_width, DW'(MAX_WIDTH));
  assign h_now    = crp_pkg::clamp_size(cfg_i.frame_height, DW'(MAX_HEIGHT));
  assign last_col = (DW'(col_q) + DW'(1)) >= w_now;
  assign last_row = (DW'(row_q) + DW'(1)) >= h_now;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + CYW'(1);
      end else begin
        col_d = col_q + CXW'(1);
      end
    end
  end

  // classification of the held pixel
  logic [DW-1:0]               colx, rowx;
  logic                        in_rows;
  logic [crp_pkg::NFLAGS-1:0]  flags;
  logic                        need;

  always_comb begin
    colx    = DW'(s1_col_q);
    rowx    = DW'(s1_row_q);
    in_rows = cfg_i.win_ok && (rowx >= cfg_i.ct) && (rowx < cfg_i.row_end);
    flags   = '0;
    flags[crp_pkg::F_TOP]   = (colx == '0) && (rowx == '0) && cfg_i.top_en;
    flags[crp_pkg::F_LEFT]  = in_rows && (colx == cfg_i.cl) && (cfg_i.bl != '0);
    flags[crp_pkg::F_PIX]   = in_rows && (colx >= cfg_i.cl) && (colx < cfg_i.col_end);
    flags[crp_pkg::F_RIGHT] = in_rows && (colx == cfg_i.col_last) && (cfg_i.br != '0);
    flags[crp_pkg::F_BOT]   = s1_last_q && cfg_i.bot_en;
    // frame ends on a pixel that made nothing: a zero length marker
    flags[crp_pkg::F_ENDFILL] = s1_last_q && (flags[crp_pkg::F_BOT:crp_pkg::F_TOP] == '0);
    need = s1_v_q && (flags != '0);
  end

  assign in_stall_o = need && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign q_push_o   = need && !q_full_i;
  assign s1_v_d     = accept || (need && q_full_i);

  always_comb begin
    q_job_o.flags = flags;
    q_job_o.fend  = s1_last_q;
    q_job_o.y     = s1_y_q;
    q_job_o.u     = s1_u_q;
    q_job_o.v     = s1_v_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      s1_v_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      s1_v_q <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q    <= col_q;
      s1_row_q    <= row_q;
      s1_last_q   <= last_col && last_row;
      s1_y_q      <= luma_i;
      s1_u_q      <= chroma_u_i;
      s1_v_data_q <= chroma_v_i;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/crp_fifo.sv @@
// short request queue between front and back
`default_nettype none
module crp_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire crp_pkg::job_t job_i,
  input  wire logic          pop_i,
  output crp_pkg::job_t      head_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int unsigned QAW = crp_pkg::QAW;
  localparam int unsigned QCW = crp_pkg::QCW;

  crp_pkg::job_t  mem_q [crp_pkg::QDEPTH];
  logic [QAW-1:0] wr_q, rd_q;
  logic [QCW-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == QCW'(crp_pkg::QDEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= wr_q + QAW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QAW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/crp_back.sv @@
// back: expands each request into its results, one per cycle while the output is not stalled, into the output register
`default_nettype none
module crp_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire crp_pkg::cfg_t        cfg_i,
  input  wire crp_pkg::job_t        head_i,
  input  wire logic                 empty_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      is_fill_run_o,
  output logic [crp_pkg::RLW-1:0]   run_length_o,
  output logic [7:0]                out_alpha_o,
  output logic [7:0]                out_luma_o,
  output logic [7:0]                out_u_o,
  output logic [7:0]                out_v_o,
  output logic                      frame_end_o
);

  localparam int unsigned NF  = crp_pkg::NFLAGS;
  localparam int unsigned RLW = crp_pkg::RLW;

  crp_pkg::job_t cur_q, cur_d;
  logic          cur_v_q, cur_v_d;
  logic          adv, emit;
  logic [NF-1:0] sel, rem;

  logic            fill_d;
  logic [RLW-1:0]  len_d;
  logic [7:0]      a_d, y_d, u_d, v_d;
  logic [23:0]     fyuv;

  assign adv  = !out_valid_o || !out_stall_i;
  assign emit = cur_v_q && adv;
  // lowest pending result first
  assign sel  = cur_q.flags & (~cur_q.flags + NF'(1));
  assign rem  = cur_q.flags & ~sel;
  assign pop_o = !empty_i && (!cur_v_q || (emit && rem == '0));
  assign fyuv = crp_pkg::fill_yuv(cfg_i.fill_colour);

  always_comb begin
    cur_d   = cur_q;
    cur_v_d = cur_v_q;
    if (pop_o) begin
      cur_d   = head_i;
      cur_v_d = 1'b1;
    end else if (emit) begin
      cur_d.flags = rem;
      cur_v_d     = rem != '0;
    end
  end

  always_comb begin
    fill_d = 1'b1;
    a_d    = cfg_i.alpha[7:0];
    y_d    = fyuv[23:16];
    u_d    = fyuv[15:8];
    v_d    = fyuv[7:0];
    if (sel[crp_pkg::F_TOP]) begin
      len_d = crp_pkg::sat_len(cfg_i.top_len);
    end else if (sel[crp_pkg::F_LEFT]) begin
      len_d = RLW'(cfg_i.bl);
    end else if (sel[crp_pkg::F_PIX]) begin
      len_d  = RLW'(1);
      fill_d = 1'b0;
      a_d    = cfg_i.alpha[15:8];
      y_d    = cur_q.y;
      u_d    = cur_q.u;
      v_d    = cur_q.v;
    end else if (sel[crp_pkg::F_RIGHT]) begin
      len_d = RLW'(cfg_i.br);
    end else if (sel[crp_pkg::F_BOT]) begin
      len_d = crp_pkg::sat_len(cfg_i.bot_len);
    end else begin
      len_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q     <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      cur_v_q <= cur_v_d;
      if (emit) begin
        out_valid_o <= 1'b1;
      end else if (adv) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (emit) begin
      is_fill_run_o <= fill_d;
      run_length_o  <= len_d;
      out_alpha_o   <= a_d;
      out_luma_o    <= y_d;
      out_u_o       <= u_d;
      out_v_o       <= v_d;
      frame_end_o   <= cur_q.fend && (rem == '0);
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/crop_pad_to_ayuv_stream.sv @@
// crop and letterbox pad of a raster pixel stream into picture pixels and fill runs
// path: an accepted pixel passes the held request register, the queue, the expansion register and the output register
// throughput: one pixel per cycle while each pixel gives at most one result and the output is not stalled; a pixel
//   with more than one result (border runs) holds the expansion stage until all are emitted, a 4-deep queue absorbs it
// window geometry is registered in two steps after a register write
// reset: counters, queue and output valid clear, registers take their reset values
`default_nettype none
module crop_pad_to_ayuv_stream #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [4:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [7:0]           luma_i,
  input  wire logic [7:0]           chroma_u_i,
  input  wire logic [7:0]           chroma_v_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      is_fill_run_o,
  output logic [crp_pkg::RLW-1:0]   run_length_o,
  output logic [7:0]                out_alpha_o,
  output logic [7:0]                out_luma_o,
  output logic [7:0]                out_u_o,
  output logic [7:0]                out_v_o,
  output logic                      frame_end_o
);

  crp_pkg::cfg_t cfg;
  crp_pkg::job_t push_job, head_job;
  logic          q_push, q_pop, q_full, q_empty;

  crp_regs #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  crp_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .luma_i    (luma_i),
    .chroma_u_i(chroma_u_i),
    .chroma_v_i(chroma_v_i),
    .cfg_i     (cfg),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_job_o   (push_job)
  );

  crp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (push_job),
    .pop_i  (q_pop),
    .head_o (head_job),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  crp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_i       (head_job),
    .empty_i      (q_empty),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .is_fill_run_o(is_fill_run_o),
    .run_length_o (run_length_o),
    .out_alpha_o  (out_alpha_o),
    .out_luma_o   (out_luma_o),
    .out_u_o      (out_u_o),
    .out_v_o      (out_v_o),
    .frame_end_o  (frame_end_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_empty))
    else $error("queue read while empty");

  a_pixel_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_fill_run_o) |->
      (run_length_o == crp_pkg::RLW'(1)) && (out_alpha_o == cfg.alpha[15:8]))
    else $error("picture pixel with wrong length or alpha");

  a_stall_needs_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_full)
    else $error("input stalled without a full queue");

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// testbench of the crop and pad stream block: register setup, pixel traffic and result checks

typedef struct packed {
  logic                    fill;
  logic [crp_pkg::RLW-1:0] len;
  logic [7:0]              alpha;
  logic [7:0]              y;
  logic [7:0]              u;
  logic [7:0]              v;
  logic                    fend;
} ayuv_result_t;

class crop_pad_scoreboard;
  localparam int     FRAME_MAX = 4096;
  localparam longint RUN_CAP   = 50331648;

  logic [15:0]  regs [8];
  int           col_pos;
  int           row_pos;
  ayuv_result_t expected_q [$];
  int unsigned  errors;

  function new();
    regs[crp_pkg::REG_FRAME_WIDTH]  = 16'd320;
    regs[crp_pkg::REG_FRAME_HEIGHT] = 16'd240;
    regs[crp_pkg::REG_EDGE_LEFT]    = 16'd0;
    regs[crp_pkg::REG_EDGE_RIGHT]   = 16'd0;
    regs[crp_pkg::REG_EDGE_TOP]     = 16'd0;
    regs[crp_pkg::REG_EDGE_BOTTOM]  = 16'd0;
    regs[crp_pkg::REG_FILL_COLOUR]  = 16'd0;
    regs[crp_pkg::REG_ALPHA_VALUES] = 16'hFFFF;
    col_pos = 0;
    row_pos = 0;
    errors = 0;
  endfunction

  function logic [15:0] reg_mask(crp_pkg::reg_idx_e idx);
    case (idx)
      crp_pkg::REG_FILL_COLOUR:  return 16'h0003;
      crp_pkg::REG_ALPHA_VALUES: return 16'hFFFF;
      default:                   return 16'h1FFF;
    endcase
  endfunction

  function void write_reg(crp_pkg::reg_idx_e idx, logic [31:0] data);
    regs[idx] = data[15:0] & reg_mask(idx);
  endfunction

  function int frame_dim(logic [15:0] r);
    if (r == 16'd0) return 1;
    if (r > FRAME_MAX) return FRAME_MAX;
    return int'(r);
  endfunction

  function int edge_value(logic [15:0] r);
    return int'($signed(r[12:0]));
  endfunction

  function ayuv_result_t fill_run(longint len, logic [7:0] a, logic [7:0] fy,
                                  logic [7:0] fu, logic [7:0] fv);
    ayuv_result_t r;
    if (len > RUN_CAP) len = RUN_CAP;
    r.fill = 1'b1;
    r.len = len[crp_pkg::RLW-1:0];
    r.alpha = a;
    r.y = fy;
    r.u = fu;
    r.v = fv;
    r.fend = 1'b0;
    return r;
  endfunction

  // works out every result one accepted pixel causes and advances the raster position
  function void note_pixel(logic [7:0] py, logic [7:0] pu, logic [7:0] pv);
    int w, h, el, er, et, eb;
    int cl, cr, ct, cb, bl, br, bt, bb, cw, ch;
    longint ow;
    logic [7:0] fy, fu, fv, pa, ba;
    logic last_col, last_row;
    ayuv_result_t batch [$];
    ayuv_result_t r;
    w = frame_dim(regs[crp_pkg::REG_FRAME_WIDTH]);
    h = frame_dim(regs[crp_pkg::REG_FRAME_HEIGHT]);
    el = edge_value(regs[crp_pkg::REG_EDGE_LEFT]);
    er = edge_value(regs[crp_pkg::REG_EDGE_RIGHT]);
    et = edge_value(regs[crp_pkg::REG_EDGE_TOP]);
    eb = edge_value(regs[crp_pkg::REG_EDGE_BOTTOM]);
    cl = el > 0 ? el : 0;
    cr = er > 0 ? er : 0;
    ct = et > 0 ? et : 0;
    cb = eb > 0 ? eb : 0;
    bl = el < 0 ? -el : 0;
    br = er < 0 ? -er : 0;
    bt = et < 0 ? -et : 0;
    bb = eb < 0 ? -eb : 0;
    cw = w - cl - cr;
    ch = h - ct - cb;
    if (cw < 0) cw = 0;
    if (ch < 0) ch = 0;
    ow = longint'(bl) + cw + br;
    case (crp_pkg::fill_colour_e'(regs[crp_pkg::REG_FILL_COLOUR][1:0]))
      crp_pkg::FILL_KEY_GREEN: {fy, fu, fv} = {8'd150, 8'd46, 8'd21};
      crp_pkg::FILL_KEY_BLUE:  {fy, fu, fv} = {8'd29, 8'd255, 8'd107};
      default:                 {fy, fu, fv} = {8'd16, 8'd128, 8'd128};
    endcase
    pa = regs[crp_pkg::REG_ALPHA_VALUES][15:8];
    ba = regs[crp_pkg::REG_ALPHA_VALUES][7:0];
    last_col = col_pos >= w - 1;
    last_row = row_pos >= h - 1;

    if (col_pos == 0 && row_pos == 0 && longint'(bt) * ow > 0)
      batch.push_back(fill_run(longint'(bt) * ow, ba, fy, fu, fv));
    if (cw > 0 && ch > 0 && row_pos >= ct && row_pos < ct + ch) begin
      if (col_pos == cl && bl > 0)
        batch.push_back(fill_run(bl, ba, fy, fu, fv));
      if (col_pos >= cl && col_pos < cl + cw) begin
        r = fill_run(1, pa, py, pu, pv);
        r.fill = 1'b0;
        batch.push_back(r);
      end
      if (col_pos == cl + cw - 1 && br > 0)
        batch.push_back(fill_run(br, ba, fy, fu, fv));
    end
    if (last_col && last_row) begin
      if (longint'(bb) * ow > 0)
        batch.push_back(fill_run(longint'(bb) * ow, ba, fy, fu, fv));
      // a frame whose last pixel gives nothing still closes with an empty fill
      if (batch.size() == 0)
        batch.push_back(fill_run(0, ba, fy, fu, fv));
      r = batch.pop_back();
      r.fend = 1'b1;
      batch.push_back(r);
    end
    foreach (batch[i]) expected_q.push_back(batch[i]);

    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  task report(string msg);
    $display("%0t mismatch: %s", $time, msg);
    errors++;
  endtask

  task check_result(ayuv_result_t got);
    ayuv_result_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("result with nothing pending, fill %0b len %0d", got.fill, got.len));
      return;
    end
    want = expected_q.pop_front();
    if (got.fill !== want.fill)
      report($sformatf("is_fill_run got %0b want %0b", got.fill, want.fill));
    if (got.len !== want.len)
      report($sformatf("run_length got %0d want %0d", got.len, want.len));
    if (got.alpha !== want.alpha)
      report($sformatf("out_alpha got %0d want %0d", got.alpha, want.alpha));
    if (got.y !== want.y)
      report($sformatf("out_luma got %0d want %0d", got.y, want.y));
    if (got.u !== want.u)
      report($sformatf("out_u got %0d want %0d", got.u, want.u));
    if (got.v !== want.v)
      report($sformatf("out_v got %0d want %0d", got.v, want.v));
    if (got.fend !== want.fend)
      report($sformatf("frame_end got %0b want %0b", got.fend, want.fend));
  endtask
endclass

module tb_top;
  localparam int PERIOD = 20;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [1:0] FILL_RESERVED = 2'd3;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [4:0]              paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata;
  logic                    pready;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [7:0]              luma = '0;
  logic [7:0]              chroma_u = '0;
  logic [7:0]              chroma_v = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    is_fill;
  logic [crp_pkg::RLW-1:0] run_len;
  logic [7:0]              o_alpha;
  logic [7:0]              o_luma;
  logic [7:0]              o_u;
  logic [7:0]              o_v;
  logic                    o_fend;

  int           in_idle_pct = 0;
  int           out_idle_pct = 0;
  int           rx_hold = 0;
  logic [31:0]  cfg_words [8];
  ayuv_result_t seen;
  crop_pad_scoreboard sb;

  always #(PERIOD / 2) clk = ~clk;

  crop_pad_to_ayuv_stream uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .luma_i       (luma),
    .chroma_u_i   (chroma_u),
    .chroma_v_i   (chroma_v),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .is_fill_run_o(is_fill),
    .run_length_o (run_len),
    .out_alpha_o  (o_alpha),
    .out_luma_o   (o_luma),
    .out_u_o      (o_u),
    .out_v_o      (o_v),
    .frame_end_o  (o_fend)
  );

  // result side: random stall, or a long hold-off counted down here
  always begin
    @(negedge clk);
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold = rx_hold - 1;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
    @(posedge clk);
    if (out_valid === 1'b1 && out_stall == 1'b0) begin
      seen = '{fill: is_fill, len: run_len, alpha: o_alpha, y: o_luma, u: o_u, v: o_v,
               fend: o_fend};
      sb.check_result(seen);
    end
  end

  task apb_write(crp_pkg::reg_idx_e idx, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.write_reg(idx, data);
  endtask

  task apb_read(crp_pkg::reg_idx_e idx, output logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    data = prdata;
  endtask

  task apb_release();
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task readback_regs();
    logic [31:0]       rd;
    crp_pkg::reg_idx_e idx;
    for (int i = 0; i < 8; i++) begin
      idx = crp_pkg::reg_idx_e'(i);
      apb_read(idx, rd);
      if ((rd[15:0] & sb.reg_mask(idx)) !== sb.regs[idx])
        sb.report($sformatf("register %s reads %h want %h", idx.name(), rd, sb.regs[idx]));
    end
  endtask

  task sender_idle();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task drain_results();
    sender_idle();
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // reading back after the writes also gives the geometry time to settle
  task program_regs();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = 0; i < 8; i++) apb_write(crp_pkg::reg_idx_e'(i), cfg_words[i]);
    readback_regs();
    apb_release();
  endtask

  task send_pixel(logic [7:0] py, logic [7:0] pu, logic [7:0] pv);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    luma <= py;
    chroma_u <= pu;
    chroma_v <= pv;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_pixel(py, pu, pv);
  endtask

  task send_random(int count);
    for (int i = 0; i < count; i++)
      send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
  endtask

  function void load_regs(logic [12:0] fw, logic [12:0] fh, logic [12:0] el, logic [12:0] er,
                          logic [12:0] et, logic [12:0] eb, logic [1:0] fc, logic [15:0] al);
    cfg_words[crp_pkg::REG_FRAME_WIDTH]  = {19'd0, fw};
    cfg_words[crp_pkg::REG_FRAME_HEIGHT] = {19'd0, fh};
    cfg_words[crp_pkg::REG_EDGE_LEFT]    = {19'd0, el};
    cfg_words[crp_pkg::REG_EDGE_RIGHT]   = {19'd0, er};
    cfg_words[crp_pkg::REG_EDGE_TOP]     = {19'd0, et};
    cfg_words[crp_pkg::REG_EDGE_BOTTOM]  = {19'd0, eb};
    cfg_words[crp_pkg::REG_FILL_COLOUR]  = {30'd0, fc};
    cfg_words[crp_pkg::REG_ALPHA_VALUES] = {16'd0, al};
  endfunction

  function logic [12:0] rand_dim();
    int r;
    r = $urandom_range(19);
    if (r == 0) return 13'd0;
    if (r == 1) return 13'($urandom_range(8191, 4097));
    return 13'($urandom_range(8, 1));
  endfunction

  function logic [12:0] rand_edge();
    int r;
    int e;
    r = $urandom_range(11);
    if (r == 0) e = $urandom_range(4095);
    else if (r == 1) e = -int'($urandom_range(4096, 1));
    else e = int'($urandom_range(6)) - 3;
    return e[12:0];
  endfunction

  // unused upper bits of the data word carry noise
  task random_regs();
    logic [31:0] junk;
    for (int i = 0; i < 8; i++) begin
      junk = $urandom;
      case (crp_pkg::reg_idx_e'(i))
        crp_pkg::REG_FRAME_WIDTH, crp_pkg::REG_FRAME_HEIGHT:
          cfg_words[i] = {junk[31:13], rand_dim()};
        crp_pkg::REG_FILL_COLOUR:  cfg_words[i] = {junk[31:2], 2'($urandom_range(3))};
        crp_pkg::REG_ALPHA_VALUES: cfg_words[i] = junk;
        default:                   cfg_words[i] = {junk[31:13], rand_edge()};
      endcase
    end
    program_regs();
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    readback_regs();
    apb_release();

    // widest frame with the widest left, right and top borders: longest top run, then width lowered mid-row
    load_regs(13'h1FFF, 13'd0, 13'h1000, 13'h1000, 13'h1000, -13'sd1, crp_pkg::FILL_KEY_GREEN,
              16'hA55A);
    program_regs();
    send_pixel(8'd255, 8'd0, 8'd255);
    cfg_words[crp_pkg::REG_FRAME_WIDTH] = 32'd2;
    program_regs();
    send_pixel(8'd0, 8'd255, 8'd0);

    // one-pixel frames: every run kind from a single request
    load_regs(13'd1, 13'd1, -13'sd3, -13'sd2, -13'sd5, -13'sd7, crp_pkg::FILL_KEY_BLUE,
              16'h00FF);
    program_regs();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);

    // empty window and reserved colour, frame closes with an empty fill
    load_regs(13'd3, 13'd2, -13'sd2, -13'sd1, -13'sd2, 13'd4095, FILL_RESERVED, 16'h8001);
    program_regs();
    send_random(6);

    // cropped window inside the frame
    load_regs(13'd4, 13'd2, 13'd1, 13'd1, 13'd1, 13'd0, crp_pkg::FILL_BLACK, 16'($urandom));
    program_regs();
    send_random(8);

    for (int mode = 0; mode < 3; mode++) begin
      in_idle_pct = (mode == 0) ? 30 : (mode == 1) ? 61 : 0;
      out_idle_pct = (mode == 0) ? 61 : (mode == 1) ? 30 : 0;
      for (int ph = 0; ph < 2; ph++) begin
        random_regs();
        send_random($urandom_range(12, 8));
      end
    end

    // back-pressure: result side holds off while pixels keep coming
    load_regs(13'd4, 13'd2, -13'sd2, -13'sd2, -13'sd1, -13'sd1, crp_pkg::FILL_KEY_GREEN,
              16'($urandom));
    program_regs();
    rx_hold = 80;
    send_random(24);
    drain_results();
    send_random(10);

    drain_results();
    repeat (16) @(posedge clk);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(4_000_000);
    $display("end of test: mismatches");
    $finish;
  end
endmodule
